// ----- hdl/cop_pkg.sv -----
`default_nettype none

package cop_pkg;

  // Pixel channel and sum widths.
  localparam int unsigned CH_W   = 8;
  localparam int unsigned SUM_W  = 10;
  localparam int unsigned OPP_W  = 15;

  // Signed numerators (2r-g-b and min(r,g)-b) and their magnitudes.
  localparam int unsigned DIFF_W = 11;
  localparam int unsigned MAG_W  = 10;

  // Scaled numerator is below sum * 2**QUO_W, so the top bits seed the remainder
  // and only QUO_W restoring steps remain.
  localparam int unsigned NUM_W  = 22;
  localparam int unsigned QUO_W  = 14;
  localparam int unsigned LANES  = 4;

  localparam int unsigned STEP_W    = 4;
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(QUO_W - 1);

  // Kind of request carried in tuser bit 0.
  localparam logic REQ_SCAN    = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  // Lane order inside the divider.
  localparam int unsigned LANE_RED    = 0;
  localparam int unsigned LANE_GREEN  = 1;
  localparam int unsigned LANE_BLUE   = 2;
  localparam int unsigned LANE_YELLOW = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_HOLD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic scan_upd;
    logic latch_pix;
    logic load_div;
    logic step_div;
    logic write_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/cop_ctrl.sv -----
`default_nettype none

module cop_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_req,
  output logic               in_ready,
  input  wire cop_pkg::sts_t sts,
  output cop_pkg::cmd_t      cmd
);

  cop_pkg::state_t                  state;
  cop_pkg::state_t                  state_next;
  logic [cop_pkg::STEP_W-1:0]       step;
  logic [cop_pkg::STEP_W-1:0]       step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cop_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      cop_pkg::ST_IDLE: begin
        if (in_valid && (in_req == cop_pkg::REQ_CONVERT)) begin
          state_next = cop_pkg::ST_LOAD;
        end
      end
      cop_pkg::ST_LOAD: begin
        state_next = cop_pkg::ST_DIV;
        step_next  = '0;
      end
      cop_pkg::ST_DIV: begin
        if (step == cop_pkg::DIV_LAST) begin
          state_next = cop_pkg::ST_HOLD;
        end else begin
          step_next = step + 1'b1;
        end
      end
      cop_pkg::ST_HOLD: begin
        if (sts.out_free) begin
          state_next = cop_pkg::ST_IDLE;
        end
      end
      default: state_next = cop_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      cop_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.scan_upd  = in_valid && (in_req == cop_pkg::REQ_SCAN);
        cmd.latch_pix = in_valid && (in_req == cop_pkg::REQ_CONVERT);
      end
      cop_pkg::ST_LOAD: cmd.load_div = 1'b1;
      cop_pkg::ST_DIV:  cmd.step_div = 1'b1;
      cop_pkg::ST_HOLD: cmd.write_out = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/cop_datapath.sv -----
`default_nettype none

module cop_datapath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cop_pkg::cmd_t cmd,
  output cop_pkg::sts_t      sts,
  input  wire logic          in_fs,
  input  wire logic [23:0]   in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [71:0]        out_data,
  output logic               out_dark
);

  localparam int unsigned CW = cop_pkg::CH_W;
  localparam int unsigned SW = cop_pkg::SUM_W;
  localparam int unsigned DW = cop_pkg::DIFF_W;
  localparam int unsigned MW = cop_pkg::MAG_W;
  localparam int unsigned NW = cop_pkg::NUM_W;
  localparam int unsigned QW = cop_pkg::QUO_W;
  localparam int unsigned OW = cop_pkg::OPP_W;
  localparam int unsigned NL = cop_pkg::LANES;

  logic [SW-1:0] max_sum;
  logic [SW-1:0] in_sum;
  logic [CW-1:0] pix_r, pix_g, pix_b;

  logic [SW-1:0] pix_sum;
  logic [SW+2:0] sum_x10;
  logic          pix_dark;
  logic [CW-1:0] pix_min;
  logic [DW-1:0] diff   [NL];
  logic [MW-1:0] mag    [NL];
  logic [MW:0]   mag_x3 [NL];
  logic [NW-1:0] num    [NL];

  logic [SW-1:0] divisor;
  logic [SW-1:0] sum_hold;
  logic          dark_hold;
  logic          neg    [NL];
  logic [SW-1:0] rem    [NL];
  logic [QW-1:0] quo    [NL];
  logic [SW:0]   trial  [NL];
  logic [OW-1:0] opp    [NL];

  assign in_sum = SW'(in_data[7:0]) + SW'(in_data[15:8]) + SW'(in_data[23:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_sum <= '0;
    end else if (cmd.scan_upd) begin
      if (in_fs || (in_sum > max_sum)) begin
        max_sum <= in_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_pix) begin
      pix_r <= in_data[7:0];
      pix_g <= in_data[15:8];
      pix_b <= in_data[23:16];
    end
  end

  // Numerators, magnitudes and the dark test for the latched pixel.
  always_comb begin
    pix_sum  = SW'(pix_r) + SW'(pix_g) + SW'(pix_b);
    sum_x10  = {pix_sum, 3'b000} + {2'b00, pix_sum, 1'b0};
    pix_dark = sum_x10 <= {3'b000, max_sum};
    pix_min  = (pix_r < pix_g) ? pix_r : pix_g;
    diff[cop_pkg::LANE_RED]    = {2'b00, pix_r, 1'b0} - DW'(pix_g) - DW'(pix_b);
    diff[cop_pkg::LANE_GREEN]  = {2'b00, pix_g, 1'b0} - DW'(pix_r) - DW'(pix_b);
    diff[cop_pkg::LANE_BLUE]   = {2'b00, pix_b, 1'b0} - DW'(pix_r) - DW'(pix_g);
    diff[cop_pkg::LANE_YELLOW] = DW'(pix_min) - DW'(pix_b);
    for (int i = 0; i < NL; i++) begin
      mag[i]    = diff[i][DW-1] ? MW'(-diff[i]) : MW'(diff[i]);
      mag_x3[i] = {mag[i], 1'b0} + {1'b0, mag[i]};
    end
    // 6144 = 3 << 11 for the red, green and blue lanes, 12288 = 3 << 12 for yellow.
    for (int i = 0; i < NL - 1; i++) begin
      num[i] = {mag_x3[i], 11'b0};
    end
    num[cop_pkg::LANE_YELLOW] = {mag_x3[cop_pkg::LANE_YELLOW][MW-1:0], 12'b0};
  end

  // Four restoring dividers sharing one divisor, one quotient bit per step.
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      trial[i] = {rem[i], quo[i][QW-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      divisor   <= pix_sum;
      sum_hold  <= pix_sum;
      dark_hold <= pix_dark;
      for (int i = 0; i < NL; i++) begin
        neg[i] <= diff[i][DW-1];
        rem[i] <= SW'(num[i][NW-1:QW]);
        quo[i] <= num[i][QW-1:0];
      end
    end else if (cmd.step_div) begin
      for (int i = 0; i < NL; i++) begin
        if (trial[i] >= {1'b0, divisor}) begin
          rem[i] <= SW'(trial[i] - {1'b0, divisor});
          quo[i] <= {quo[i][QW-2:0], 1'b1};
        end else begin
          rem[i] <= SW'(trial[i]);
          quo[i] <= {quo[i][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      opp[i] = neg[i] ? OW'(0 - {1'b0, quo[i]}) : {1'b0, quo[i]};
    end
  end

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_out) begin
      out_dark <= dark_hold;
      if (dark_hold) begin
        out_data <= '0;
      end else begin
        out_data <= {2'b00, opp[cop_pkg::LANE_YELLOW], opp[cop_pkg::LANE_BLUE],
                     opp[cop_pkg::LANE_GREEN], opp[cop_pkg::LANE_RED], sum_hold};
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/color_opponency_channels_unit.sv -----
`default_nettype none

// Color opponency unit. Each frame is streamed twice over the slave side: first
// as scan beats (tuser bit 0 low), which track the largest channel sum r+g+b of
// the frame, with tuser bit 1 restarting that maximum on the frame's first beat;
// then as convert beats (tuser bit 0 high), each of which yields one master beat
// with the sum and four opponent ratios in signed Q3.12, truncated toward zero:
// red 1.5(2r-g-b)/s, green 1.5(2g-r-b)/s, blue 1.5(2b-r-g)/s and yellow
// 3(min(r,g)-b)/s. A pixel whose sum is at most a tenth of the stored maximum
// comes out as all zeros with the dark flag set. A scan beat gives no output.
// A convert beat holds off the next beat until its result is written: the
// pixel is latched on acceptance, the numerators and the dark test are formed
// and loaded into the four restoring dividers, which share the pixel sum as
// divisor and produce one quotient bit per cycle, and the result goes into the
// output register. A result waiting in the output register does not stop the
// next beat from being accepted; only a second result waiting behind it does.
module color_opponency_channels_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  wire logic [1:0]  s_tuser,   // req_type[0], frame_start[1]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // intensity_sum[9:0], red_opp[24:10],
                                      // green_opp[39:25], blue_opp[54:40],
                                      // yellow_opp[69:55], zero fill[71:70]
  output logic [0:0]       m_tuser    // dark_pixel[0]
);

  cop_pkg::cmd_t cmd;
  cop_pkg::sts_t sts;

  // Sequencer: accepts beats, steps the divider, and waits for a free output slot.
  cop_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_req   (s_tuser[0]),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Frame maximum, numerator formation, shared-divisor divider and output register.
  cop_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_fs     (s_tuser[1]),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_dark  (m_tuser[0])
  );

endmodule

`default_nettype wire

// ----- hdl/cop_checker.sv -----
`default_nettype none

module cop_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  // A stalled result beat keeps its content.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // Dark pixels carry all-zero data.
  a_dark_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 72'd0)
    else $error("dark pixel with nonzero data");

  // A zero sum is always dark, so a bright pixel has a nonzero sum.
  a_bright_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[9:0] != 10'd0)
    else $error("bright pixel with zero intensity sum");

  // After a convert beat the unit is busy dividing.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
    else $error("input accepted right after a convert beat");

endmodule

bind color_opponency_channels_unit cop_checker u_cop_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/color_opponency_channels_unit_tb.sv -----
module color_opponency_channels_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The longest run of cycles with no beat on either side that a correct
  // run can show. Random stalls on both sides come on top of the convert
  // processing time. This limit leaves a wide margin over that.
  localparam int unsigned STALL_LIMIT  = 4000;
  // After the last expected result the bench keeps watching the output,
  // so that late stray result beats are caught.
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS  = 350;
  localparam int unsigned SCALE_RGB    = 6144;
  localparam int unsigned SCALE_YELLOW = 12288;

  // These are the fields of one master beat, in m_tdata order, then the m_tuser flag.
  typedef struct {
    logic [cop_pkg::SUM_W-1:0] intensity_sum;
    logic [cop_pkg::OPP_W-1:0] red_opp;
    logic [cop_pkg::OPP_W-1:0] green_opp;
    logic [cop_pkg::OPP_W-1:0] blue_opp;
    logic [cop_pkg::OPP_W-1:0] yellow_opp;
    logic                      dark_pixel;
  } channels_t;

  // This class predicts the block's results. It keeps its own copy of the
  // frame maximum and a queue of the channel results expected from convert
  // beats that were accepted and whose results have not yet come out.
  class opponency_scoreboard;
    logic [cop_pkg::SUM_W-1:0] frame_max;
    channels_t                 expected_channels[$];
    int unsigned               errors;

    function new();
      frame_max = '0;
      errors    = 0;
    endfunction

    // This computes scale*diff/sum, truncated toward zero, as a 15-bit
    // two's complement pattern.
    function logic [cop_pkg::OPP_W-1:0] opponent_ratio(int diff, int scale, int sum);
      int mag;
      int quo;
      mag = (diff < 0) ? -diff : diff;
      quo = (mag * scale) / sum;
      return (diff < 0) ? cop_pkg::OPP_W'(-quo) : cop_pkg::OPP_W'(quo);
    endfunction

    function void note_pixel(logic [1:0] user, logic [23:0] data);
      int r;
      int g;
      int b;
      int sum;
      int mn;
      channels_t res;
      r   = data[7:0];
      g   = data[15:8];
      b   = data[23:16];
      sum = r + g + b;
      if (user[0] == cop_pkg::REQ_SCAN) begin
        if (user[1]) frame_max = '0;
        if (sum > frame_max) frame_max = cop_pkg::SUM_W'(sum);
        return;
      end
      res = '{default: '0};
      if (10 * sum <= frame_max) begin
        // Dark pixels, including black ones, give all zeros and the flag.
        res.dark_pixel = 1'b1;
      end else begin
        mn = (r < g) ? r : g;
        res.intensity_sum = cop_pkg::SUM_W'(sum);
        res.red_opp       = opponent_ratio(2 * r - g - b, SCALE_RGB, sum);
        res.green_opp     = opponent_ratio(2 * g - r - b, SCALE_RGB, sum);
        res.blue_opp      = opponent_ratio(2 * b - r - g, SCALE_RGB, sum);
        res.yellow_opp    = opponent_ratio(mn - b, SCALE_YELLOW, sum);
      end
      expected_channels.push_back(res);
    endfunction

    function void compare_field(string name, logic [cop_pkg::OPP_W-1:0] exp_val,
                                logic [cop_pkg::OPP_W-1:0] act_val);
      if (exp_val !== act_val) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_beat(logic [71:0] data, logic [0:0] user);
      channels_t exp_res;
      if (expected_channels.size() == 0) begin
        $error("unexpected result beat: data 0x%0h, dark %0b", data, user);
        errors++;
        return;
      end
      exp_res = expected_channels.pop_front();
      compare_field("intensity_sum", cop_pkg::OPP_W'(exp_res.intensity_sum),
                    cop_pkg::OPP_W'(data[9:0]));
      compare_field("red_opp",    exp_res.red_opp,    data[24:10]);
      compare_field("green_opp",  exp_res.green_opp,  data[39:25]);
      compare_field("blue_opp",   exp_res.blue_opp,   data[54:40]);
      compare_field("yellow_opp", exp_res.yellow_opp, data[69:55]);
      compare_field("zero_fill",  '0,                 cop_pkg::OPP_W'(data[71:70]));
      compare_field("dark_pixel", cop_pkg::OPP_W'(exp_res.dark_pixel),
                    cop_pkg::OPP_W'(user[0]));
    endfunction

    function int unsigned pending();
      return expected_channels.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;    // red[7:0], green[15:8], blue[23:16]
  logic [1:0]  s_tuser;    // req_type[0], frame_start[1]
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;    // intensity_sum, red/green/blue/yellow_opp, zero fill
  logic [0:0]  m_tuser;    // dark_pixel[0]

  opponency_scoreboard sb = new();

  // These percentages set how often the sender idles and the receiver stalls.
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned items_sent;
  int unsigned quiet_cycles;

  color_opponency_channels_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver decides at each falling edge whether it takes a beat at the
  // next rising edge. This is the only place where m_tready is assigned.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Both sides are sampled at the rising edge. A result beat is checked
  // before an input beat from the same edge is noted. This cannot change
  // the outcome, because a result never belongs to the pixel that is
  // accepted on the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser);
      if (s_tvalid && s_tready) sb.note_pixel(s_tuser, s_tdata);
    end
  end

  // The watchdog counts cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // This task is entered at a falling edge and leaves at the falling edge
  // after its beat was taken. That way tvalid stays high from one beat to
  // the next when the sender does not idle.
  task automatic send_pixel(logic req, logic fs, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = {fs, req};
    s_tdata  = {b, g, r};
    forever begin
      @(posedge clk);
      if (s_tready) break;
      @(negedge clk);
    end
    @(negedge clk);
    items_sent++;
  endtask

  // Channel values are a mix of full range, extremes and small values.
  // The small values make dark pixels common against a bright maximum.
  function automatic logic [7:0] random_channel();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 4) return 8'($urandom_range(255));
    if (pick < 6) return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
    return 8'($urandom_range(30));
  endfunction

  // A well-formed frame is a scan pass, whose first beat restarts the
  // maximum, followed by a convert pass over the same pixels. The frame
  // start flag on convert beats is random, because the block must ignore it.
  task automatic send_frame();
    logic [7:0] rs[8];
    logic [7:0] gs[8];
    logic [7:0] bs[8];
    int unsigned n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      rs[i] = random_channel();
      gs[i] = random_channel();
      bs[i] = random_channel();
      send_pixel(cop_pkg::REQ_SCAN, i == 0, rs[i], gs[i], bs[i]);
    end
    for (int i = 0; i < n; i++) begin
      send_pixel(cop_pkg::REQ_CONVERT, $urandom_range(1) != 0, rs[i], gs[i], bs[i]);
    end
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
    int unsigned stop_at;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    stop_at        = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        // Noise breaks frames. It includes stray scans, converts with no
        // scan before them, and frame start flags in odd places.
        repeat ($urandom_range(1, 4)) begin
          send_pixel($urandom_range(1) != 0, $urandom_range(1) != 0,
                     random_channel(), random_channel(), random_channel());
        end
      end else begin
        send_frame();
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    items_sent     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // These directed beats come before any scan. The maximum is zero after
    // reset, so only a black pixel is dark. A frame start flag on a convert
    // beat must not change anything.
    send_pixel(cop_pkg::REQ_CONVERT, 1'b0, 8'd0,   8'd0,   8'd0);
    send_pixel(cop_pkg::REQ_CONVERT, 1'b0, 8'd1,   8'd0,   8'd0);
    send_pixel(cop_pkg::REQ_CONVERT, 1'b1, 8'd10,  8'd20,  8'd30);
    // A white scan sets the maximum to the largest sum. The converts below
    // cover the largest and smallest ratios and the edge of the dark test.
    // A sum of 76 is dark and a sum of 77 is not.
    send_pixel(cop_pkg::REQ_SCAN,    1'b1, 8'd255, 8'd255, 8'd255);
    send_pixel(cop_pkg::REQ_SCAN,    1'b0, 8'd0,   8'd0,   8'd0);
    send_pixel(cop_pkg::REQ_CONVERT, 1'b0, 8'd255, 8'd255, 8'd255);
    send_pixel(cop_pkg::REQ_CONVERT, 1'b0, 8'd255, 8'd0,   8'd0);
    send_pixel(cop_pkg::REQ_CONVERT, 1'b0, 8'd0,   8'd255, 8'd0);
    send_pixel(cop_pkg::REQ_CONVERT, 1'b0, 8'd0,   8'd0,   8'd255);
    send_pixel(cop_pkg::REQ_CONVERT, 1'b0, 8'd255, 8'd255, 8'd0);
    send_pixel(cop_pkg::REQ_CONVERT, 1'b0, 8'd0,   8'd0,   8'd0);
    send_pixel(cop_pkg::REQ_CONVERT, 1'b0, 8'd25,  8'd25,  8'd26);
    send_pixel(cop_pkg::REQ_CONVERT, 1'b0, 8'd25,  8'd25,  8'd27);
    send_pixel(cop_pkg::REQ_CONVERT, 1'b0, 8'd200, 8'd7,   8'd131);
    // A frame start on a black scan sets the maximum back to zero.
    send_pixel(cop_pkg::REQ_SCAN,    1'b1, 8'd0,   8'd0,   8'd0);
    send_pixel(cop_pkg::REQ_CONVERT, 1'b0, 8'd0,   8'd0,   8'd0);
    send_pixel(cop_pkg::REQ_CONVERT, 1'b0, 8'd0,   8'd0,   8'd1);
    // A scan without a frame start keeps the larger of the old and new sums.
    send_pixel(cop_pkg::REQ_SCAN,    1'b0, 8'd100, 8'd0,   8'd0);
    send_pixel(cop_pkg::REQ_SCAN,    1'b0, 8'd50,  8'd0,   8'd0);
    send_pixel(cop_pkg::REQ_CONVERT, 1'b0, 8'd5,   8'd5,   8'd0);
    send_pixel(cop_pkg::REQ_CONVERT, 1'b0, 8'd5,   8'd5,   8'd1);

    // The random part runs in four idling phases: no idling, sender idle,
    // receiver stalling, and both together.
    run_phase(0, 0);
    run_phase(65, 0);
    run_phase(0, 65);
    run_phase(36, 36);
    s_tvalid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
